// ===== design/rbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rijndael cipher package
// Shared types, constants and byte-level functions of the cipher core.
// ----------------------------------------------------------------------------
package rbc_pkg;

   localparam int RoundKeyWords = 120;
   localparam int RkAddrWidth   = $clog2(RoundKeyWords);

   localparam logic [2:0] CSR_KEY_0       = 3'd0;
   localparam logic [2:0] CSR_KEY_1       = 3'd1;
   localparam logic [2:0] CSR_KEY_2       = 3'd2;
   localparam logic [2:0] CSR_KEY_3       = 3'd3;
   localparam logic [2:0] CSR_KEY_LENGTH  = 3'd4;
   localparam logic [2:0] CSR_BLOCK_LENGTH = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_LOAD,
      ST_ROUND,
      ST_DONE
   } state_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = '0;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = xtime(x);
      end
      gmul = p;
   endfunction

   // Inverse by a^254 over a fixed square-and-multiply chain; used only to
   // build the constant tables at elaboration.
   function automatic logic [7:0] ginv(input logic [7:0] a);
      logic [7:0] r;
      logic [7:0] b;
      r = 8'h01;
      b = a;
      for (int i = 0; i < 8; i++) begin
         if (i != 0) r = gmul(r, b);
         b = gmul(b, b);
      end
      ginv = r;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
      rotl8 = (x << n) | (x >> (8 - n));
   endfunction

   function automatic logic [7:0] sbox_calc(input logic [7:0] x);
      logic [7:0] b;
      b = ginv(x);
      sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
   endfunction

   function automatic logic [7:0] inv_sbox_calc(input logic [7:0] s);
      inv_sbox_calc = ginv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
   endfunction

   typedef logic [7:0] byte_table_type [256];

   function automatic byte_table_type fill_subst_table(input logic inverse);
      byte_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = inverse ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
      end
      fill_subst_table = t;
   endfunction

   localparam byte_table_type SboxTable    = fill_subst_table(1'b0);
   localparam byte_table_type InvSboxTable = fill_subst_table(1'b1);

   function automatic logic [3:0] code_to_words(input logic [1:0] code);
      code_to_words = (code == 2'd0) ? 4'd4 : ((code == 2'd1) ? 4'd6 : 4'd8);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SboxTable[w[31:24]], SboxTable[w[23:16]],
                  SboxTable[w[15:8]], SboxTable[w[7:0]]};
   endfunction

endpackage

// ===== design/rbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module rbc_ram #(
   parameter int Width = 32,
   parameter int Depth = 120
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/rijndael_block_cipher.sv =====
// ----------------------------------------------------------------------------
// Rijndael block cipher
// Iterative cipher core with a round key memory and one column per cycle.
// ----------------------------------------------------------------------------
// Encrypts or decrypts one block of 16, 24 or 32 bytes under a key of 16, 24
// or 32 bytes. After a write to a key or length register the key schedule is
// expanded into a 120-word round key memory, one word per cycle, before the
// next block. A block then passes through the load state, the round state
// (one column at a time for each key addition) and the output register:
// the single read port of the round key memory hands out one 32-bit word a
// cycle, so the core processes one column a cycle, for Nr+1 key additions.
// The result is valid once the last key addition is through; when the
// schedule is rebuilt first, the expansion comes before the load. No new
// request is taken while a block is in flight; the result stays in its
// output register until transferred, and a new request is taken in the same
// cycle the result leaves.
// ----------------------------------------------------------------------------
module rijndael_block_cipher
   import rbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [63:0] req_block_word_0,
   input  logic [63:0] req_block_word_1,
   input  logic [63:0] req_block_word_2,
   input  logic [63:0] req_block_word_3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_word_0,
   output logic [63:0] rsp_out_word_1,
   output logic [63:0] rsp_out_word_2,
   output logic [63:0] rsp_out_word_3
);

   state_type state_ff, state_in;

   logic [63:0] key_ff [4];
   logic [1:0]  klen_ff, blen_ff;
   logic        keys_ready_ff, keys_ready_in;

   logic [3:0]  nk, nb, nr;
   logic [6:0]  total;

   // Key expansion keeps the last Nk words in a shift window.
   logic [31:0] win_ff [8];
   logic [31:0] win_in [8];
   logic [6:0]  idx_ff, idx_in;
   logic [2:0]  kmod_ff, kmod_in;
   logic [7:0]  rcon_ff, rcon_in;

   // Cipher state: 32 bytes, byte i at s_ff[i].
   logic [7:0]  s_ff [32];
   logic [7:0]  s_in [32];
   logic        dec_ff, dec_in;
   logic [3:0]  round_ff, round_in;
   logic [2:0]  col_ff, col_in;
   logic [63:0] out_ff [4];
   logic [63:0] out_in [4];

   logic                   wr_en;
   logic [RkAddrWidth-1:0] wr_addr, rd_addr;
   logic [31:0]            wr_data, rd_data;
   logic [31:0]            exp_word;

   rbc_ram #(.Width(32), .Depth(RoundKeyWords)) u_rk_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign nk    = code_to_words(klen_ff);
   assign nb    = code_to_words(blen_ff);
   assign nr    = ((nk > nb) ? nk : nb) + 4'd6;
   assign total = 7'(nb) * (7'(nr) + 7'd1);

   assign csr_ready = (state_ff == ST_IDLE) && !rsp_valid;
   assign rsp_valid = (state_ff == ST_DONE);
   assign req_ready = ((state_ff == ST_IDLE) && !csr_valid) ||
                      ((state_ff == ST_DONE) && rsp_ready);
   assign rsp_out_word_0 = out_ff[0];
   assign rsp_out_word_1 = out_ff[1];
   assign rsp_out_word_2 = out_ff[2];
   assign rsp_out_word_3 = out_ff[3];

   // Next key word from the window: win[nk-1] is w[i-1], win[0] is w[i-nk].
   always_comb begin
      logic [31:0] t;
      t = win_ff[3'(nk - 4'd1)];
      if (kmod_ff == 3'd0) begin
         t = sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && kmod_ff == 3'd4) begin
         t = sub_word(t);
      end
      exp_word = win_ff[0] ^ t;
   end

   // Round processing on the column whose key word arrives this cycle.
   // The read issued for step k returns in the next cycle, so the round and
   // column registers name the word on rd_data.
   logic [7:0]  t_s [32];
   logic [7:0]  sh_s [32];
   logic        last_col, last_round, first_round;
   logic [6:0]  rd_word;

   always_comb begin
      logic [2:0] sh;
      logic [3:0] cs;
      logic [7:0] a [4];
      logic [7:0] b [4];
      logic [4:0] base;
      logic [2:0] d;
      sh = '0;
      cs = '0;
      d  = '0;
      for (int i = 0; i < 32; i++) begin
         s_in[i] = s_ff[i];
         sh_s[i] = s_ff[i];
         t_s[i]  = s_ff[i];
      end
      last_col    = (col_ff == 3'(nb - 4'd1));
      first_round = dec_ff ? (round_ff == nr) : (round_ff == 4'd0);
      last_round  = dec_ff ? (round_ff == 4'd0) : (round_ff == nr);
      base = {col_ff, 2'b00};
      // Key addition on the current column.
      for (int r = 0; r < 4; r++) begin
         a[r] = s_ff[base + 5'(r)] ^ rd_data[31 - 8 * r -: 8];
      end
      // Decryption mixes after the key addition (skip first and last).
      if (dec_ff && !first_round && !last_round) begin
         for (int r = 0; r < 4; r++) begin
            b[r] = gmul(8'h0e, a[r]) ^ gmul(8'h0b, a[(r + 1) % 4]) ^
                   gmul(8'h0d, a[(r + 2) % 4]) ^ gmul(8'h09, a[(r + 3) % 4]);
         end
      end else begin
         for (int r = 0; r < 4; r++) b[r] = a[r];
      end
      for (int r = 0; r < 4; r++) s_in[base + 5'(r)] = b[r];
      // At the end of a round (not the final one) apply the next round's
      // byte-wide steps to the whole state: substitute, shift, and mix for
      // encryption. The shifted column index wraps at most once, since the
      // offset never exceeds the block width.
      if (last_col && !last_round) begin
         for (int r = 0; r < 4; r++) begin
            sh = (nb == 4'd8 && r >= 2) ? 3'(r + 1) : 3'(r);
            for (int c = 0; c < 8; c++) begin
               if (4'(c) < nb) begin
                  cs = 4'(c) + 4'(sh);
                  d = (cs >= nb) ? 3'(cs - nb) : 3'(cs);
                  if (dec_ff) begin
                     sh_s[r + 4 * d] = InvSboxTable[s_in[r + 4 * c]];
                  end else begin
                     sh_s[r + 4 * c] = SboxTable[s_in[r + 4 * d]];
                  end
               end
            end
         end
         for (int c = 0; c < 8; c++) begin
            for (int r = 0; r < 4; r++) a[r] = sh_s[4 * c + r];
            for (int r = 0; r < 4; r++) begin
               if (!dec_ff && round_ff != 4'(nr - 4'd1)) begin
                  t_s[4 * c + r] = xtime(a[r]) ^ xtime(a[(r + 1) % 4]) ^
                                   a[(r + 1) % 4] ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
               end else begin
                  t_s[4 * c + r] = a[r];
               end
            end
         end
         for (int i = 0; i < 32; i++) s_in[i] = t_s[i];
      end
   end

   always_comb begin
      state_in      = state_ff;
      keys_ready_in = keys_ready_ff;
      idx_in        = idx_ff;
      kmod_in       = kmod_ff;
      rcon_in       = rcon_ff;
      dec_in        = dec_ff;
      round_in      = round_ff;
      col_in        = col_ff;
      for (int i = 0; i < 8; i++) win_in[i] = win_ff[i];
      for (int i = 0; i < 4; i++) out_in[i] = out_ff[i];
      wr_en   = 1'b0;
      wr_addr = idx_ff[RkAddrWidth-1:0];
      wr_data = (idx_ff < 7'(nk)) ? win_ff[idx_ff[2:0]] : exp_word;
      rd_word = 7'(round_ff) * 7'(nb) + 7'(col_ff);
      rd_addr = rd_word[RkAddrWidth-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_ready) begin
               keys_ready_in = (csr_index > CSR_BLOCK_LENGTH) ? keys_ready_ff : 1'b0;
            end else if (req_valid && req_ready) begin
               dec_in = req_command;
               state_in = keys_ready_ff ? ST_LOAD : ST_EXPAND;
               for (int i = 0; i < 8; i++) begin
                  win_in[i] = key_ff[i / 2][(i % 2 == 0) ? 63 : 31 -: 32];
               end
               idx_in  = '0;
               kmod_in = '0;
               rcon_in = 8'h01;
            end
         end
         ST_EXPAND: begin
            wr_en = 1'b1;
            idx_in = idx_ff + 7'd1;
            if (idx_ff >= 7'(nk)) begin
               for (int i = 0; i < 7; i++) win_in[i] = win_ff[i + 1];
               win_in[3'(nk - 4'd1)] = exp_word;
               if (kmod_ff == 3'd0) rcon_in = xtime(rcon_ff);
               kmod_in = (kmod_ff == 3'(nk - 4'd1)) ? 3'd0 : kmod_ff + 3'd1;
            end
            if (idx_ff == total - 7'd1) begin
               state_in = ST_LOAD;
               keys_ready_in = 1'b1;
            end
         end
         ST_LOAD: begin
            round_in = dec_ff ? nr : 4'd0;
            col_in   = '0;
            rd_word  = dec_ff ? 7'(nr) * 7'(nb) : 7'd0;
            rd_addr  = rd_word[RkAddrWidth-1:0];
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (last_col) begin
               col_in = '0;
               round_in = dec_ff ? round_ff - 4'd1 : round_ff + 4'd1;
               if (last_round) begin
                  state_in = ST_DONE;
                  for (int w = 0; w < 4; w++) begin
                     for (int k = 0; k < 8; k++) begin
                        out_in[w][63 - 8 * k -: 8] =
                           (5'(8 * w + k) < 5'(4 * nb)) || (nb == 4'd8) ?
                           s_in[8 * w + k] : 8'h00;
                     end
                  end
               end
            end else begin
               col_in = col_ff + 3'd1;
            end
            rd_word = 7'(round_in) * 7'(nb) + 7'(col_in);
            rd_addr = rd_word[RkAddrWidth-1:0];
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
               if (req_valid) begin
                  dec_in = req_command;
                  state_in = keys_ready_ff ? ST_LOAD : ST_EXPAND;
                  for (int i = 0; i < 8; i++) begin
                     win_in[i] = key_ff[i / 2][(i % 2 == 0) ? 63 : 31 -: 32];
                  end
                  idx_in  = '0;
                  kmod_in = '0;
                  rcon_in = 8'h01;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Input block captured when a request transfers.
   logic [7:0] blk [32];
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         blk[k]      = req_block_word_0[63 - 8 * k -: 8];
         blk[8 + k]  = req_block_word_1[63 - 8 * k -: 8];
         blk[16 + k] = req_block_word_2[63 - 8 * k -: 8];
         blk[24 + k] = req_block_word_3[63 - 8 * k -: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         keys_ready_ff <= 1'b0;
         klen_ff       <= '0;
         blen_ff       <= '0;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else begin
         state_ff      <= state_in;
         keys_ready_ff <= keys_ready_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_KEY_0:        key_ff[0] <= csr_data;
               CSR_KEY_1:        key_ff[1] <= csr_data;
               CSR_KEY_2:        key_ff[2] <= csr_data;
               CSR_KEY_3:        key_ff[3] <= csr_data;
               CSR_KEY_LENGTH:   klen_ff   <= csr_data[1:0];
               CSR_BLOCK_LENGTH: blen_ff   <= csr_data[1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      kmod_ff  <= kmod_in;
      rcon_ff  <= rcon_in;
      dec_ff   <= dec_in;
      round_ff <= round_in;
      col_ff   <= col_in;
      for (int i = 0; i < 8; i++) win_ff[i] <= win_in[i];
      for (int i = 0; i < 4; i++) out_ff[i] <= out_in[i];
      if (req_valid && req_ready) begin
         for (int i = 0; i < 32; i++) s_ff[i] <= blk[i];
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 32; i++) s_ff[i] <= s_in[i];
      end
   end

endmodule

// ===== design/rbc_checker.sv =====
// ----------------------------------------------------------------------------
// Rijndael cipher port checker
// Port-level checks of the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
module rbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_out_word_0
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_word_0))
      else $error("result changed while stalled");

   a_no_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !csr_ready)
      else $error("configuration taken with a result pending");

   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result appeared right after request");

   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(csr_valid && csr_ready && req_valid && req_ready))
      else $error("request and configuration in one cycle");

endmodule

bind rijndael_block_cipher rbc_checker u_rbc_checker (
   .clock         (clock),
   .reset         (reset),
   .csr_valid     (csr_valid),
   .csr_ready     (csr_ready),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_word_0(rsp_out_word_0)
);

// ===== tb/rijndael_block_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// Rijndael block cipher testbench
// Drives random and directed blocks under many key and block sizes and checks
// every result block against a cipher computed inside the testbench.
// ----------------------------------------------------------------------------
// The initial block runs the test in phases. Each phase programs all six
// configuration registers while the core is idle, then fills a queue of
// pending blocks. A clocked driver offers them on the request channel, and on
// every transfer it computes the expected result block from the current key
// and size settings. A clocked monitor takes result transfers, compares them
// word by word with the oldest expected block, and drives the response ready
// with random stalls. Between phases the sender waits until every expected
// result has come back.
// ----------------------------------------------------------------------------
module rijndael_block_cipher_tb;
   import rbc_pkg::*;

   // Indexes beyond the register map; writes to them must be ignored.
   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;
   localparam logic       CMD_ENCRYPT = 1'b0;
   localparam logic       CMD_DECRYPT = 1'b1;
   localparam int         CycleLimit  = 4000000;

   typedef struct packed {
      logic         command;
      logic [255:0] block;
   } cipher_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = 1'b0;
   logic [63:0] req_block_word_0 = '0;
   logic [63:0] req_block_word_1 = '0;
   logic [63:0] req_block_word_2 = '0;
   logic [63:0] req_block_word_3 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_out_word_0;
   logic [63:0] rsp_out_word_1;
   logic [63:0] rsp_out_word_2;
   logic [63:0] rsp_out_word_3;

   rijndael_block_cipher u_dut (.*);

   always #2 clock = ~clock;

   // Shadow copy of the configuration and of the key schedule.
   logic [255:0] key_bits;
   logic [1:0]   key_code;
   logic [1:0]   blk_code;
   logic [31:0]  sched_words [120];
   logic         sched_valid;
   logic [7:0]   fwd_sub [256];
   logic [7:0]   rev_sub [256];

   cipher_item_type pending_items [$];
   logic [255:0] expected_blocks [$];
   int           mismatches = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           hold_request = 0;
   int           hold_seen = 0;
   int           hold_left = 0;

   // ---------------------------------------------------------------- GF(2^8)
   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = gf_double(a);
      end
      return acc;
   endfunction

   // The inverse is a^254; zero maps to zero.
   function automatic logic [7:0] gf_reciprocal(input logic [7:0] a);
      logic [7:0] acc;
      acc = 8'h01;
      for (int i = 0; i < 254; i++) acc = gf_product(acc, a);
      return acc;
   endfunction

   function automatic logic [7:0] rot_byte(input logic [7:0] x, input int n);
      return (x << n) | (x >> (8 - n));
   endfunction

   function automatic int code_words(input logic [1:0] code);
      return (code == 2'd0) ? 4 : ((code == 2'd1) ? 6 : 8);
   endfunction

   function automatic logic [31:0] sub_bytes32(input logic [31:0] w);
      return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
   endfunction

   // Expands the key schedule into the shadow store, as the core does after
   // a write to a key or length register.
   task automatic expand_schedule();
      int nk, nb, nr, total;
      logic [31:0] t;
      logic [7:0]  rcon;
      nk = code_words(key_code);
      nb = code_words(blk_code);
      nr = ((nk > nb) ? nk : nb) + 6;
      total = nb * (nr + 1);
      rcon = 8'h01;
      for (int i = 0; i < nk; i++) sched_words[i] = key_bits[255 - 32 * i -: 32];
      for (int i = nk; i < total; i++) begin
         t = sched_words[i - 1];
         if (i % nk == 0) begin
            t = sub_bytes32({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
            rcon = gf_double(rcon);
         end else if (nk > 6 && i % nk == 4) begin
            t = sub_bytes32(t);
         end
         sched_words[i] = sched_words[i - nk] ^ t;
      end
      sched_valid = 1'b1;
   endtask

   // Computes the result block of one request under the shadow settings.
   task automatic cipher_result(input cipher_item_type item, output logic [255:0] result);
      logic [7:0] st [32];
      logic [7:0] tmp [32];
      logic [7:0] col [4];
      logic [7:0] mfwd [4];
      logic [7:0] minv [4];
      logic [31:0] k;
      int nk, nb, nr, sh, d, rk;
      mfwd = '{8'h02, 8'h03, 8'h01, 8'h01};
      minv = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      if (!sched_valid) expand_schedule();
      nk = code_words(key_code);
      nb = code_words(blk_code);
      nr = ((nk > nb) ? nk : nb) + 6;
      for (int i = 0; i < 32; i++) st[i] = (i < 4 * nb) ? item.block[255 - 8 * i -: 8] : 8'h00;
      for (int step = 0; step <= nr; step++) begin
         rk = (item.command == CMD_DECRYPT) ? nr - step : step;
         if (step > 0) begin
            // Row shift, then byte substitution (they commute).
            for (int r = 0; r < 4; r++) begin
               sh = (nb == 8 && r >= 2) ? r + 1 : r;
               for (int c = 0; c < nb; c++) begin
                  d = (c + sh) % nb;
                  if (item.command == CMD_DECRYPT) tmp[r + 4 * d] = st[r + 4 * c];
                  else tmp[r + 4 * c] = st[r + 4 * d];
               end
            end
            for (int i = 0; i < 4 * nb; i++)
               st[i] = (item.command == CMD_DECRYPT) ? rev_sub[tmp[i]] : fwd_sub[tmp[i]];
            // Forward column mixing precedes the key; the inverse follows it.
            if (item.command == CMD_ENCRYPT && step < nr) begin
               for (int c = 0; c < nb; c++) begin
                  for (int j = 0; j < 4; j++) col[j] = st[4 * c + j];
                  for (int r = 0; r < 4; r++) begin
                     st[4 * c + r] = 8'h00;
                     for (int j = 0; j < 4; j++)
                        st[4 * c + r] ^= gf_product(mfwd[(j - r + 4) & 3], col[j]);
                  end
               end
            end
         end
         for (int c = 0; c < nb; c++) begin
            k = sched_words[rk * nb + c];
            for (int r = 0; r < 4; r++) st[4 * c + r] ^= k[31 - 8 * r -: 8];
         end
         if (item.command == CMD_DECRYPT && step > 0 && step < nr) begin
            for (int c = 0; c < nb; c++) begin
               for (int j = 0; j < 4; j++) col[j] = st[4 * c + j];
               for (int r = 0; r < 4; r++) begin
                  st[4 * c + r] = 8'h00;
                  for (int j = 0; j < 4; j++)
                     st[4 * c + r] ^= gf_product(minv[(j - r + 4) & 3], col[j]);
               end
            end
         end
      end
      result = '0;
      for (int i = 0; i < 4 * nb; i++) result[255 - 8 * i -: 8] = st[i];
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("mismatch on %s: expected %h, got %h", what, want, got);
      mismatches++;
   endtask

   // ------------------------------------------------------------------ Driver
   // Offers pending blocks on the request channel. The expected result is
   // computed at the edge of each transfer, with the settings then in force.
   always @(posedge clock) begin
      cipher_item_type offered, next_item;
      logic [255:0] predicted;
      logic         offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            offered.command = req_command;
            offered.block = {req_block_word_0, req_block_word_1,
                             req_block_word_2, req_block_word_3};
            cipher_result(offered, predicted);
            expected_blocks.push_back(predicted);
            offer = 1'b0;
         end
         // A block already offered stays up until its transfer.
         if (!offer && pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = pending_items.pop_front();
            req_command <= next_item.command;
            req_block_word_0 <= next_item.block[255:192];
            req_block_word_1 <= next_item.block[191:128];
            req_block_word_2 <= next_item.block[127:64];
            req_block_word_3 <= next_item.block[63:0];
            offer = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // ----------------------------------------------------------------- Monitor
   always @(posedge clock) begin
      logic [255:0] want;
      logic [255:0] got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_word_0, rsp_out_word_1, rsp_out_word_2, rsp_out_word_3};
            if (expected_blocks.size() == 0) begin
               report_mismatch("out_word_0 with no block outstanding", 64'h0,
                               got[255:192]);
            end else begin
               want = expected_blocks.pop_front();
               if (want[255:192] !== got[255:192])
                  report_mismatch("out_word_0", want[255:192], got[255:192]);
               if (want[191:128] !== got[191:128])
                  report_mismatch("out_word_1", want[191:128], got[191:128]);
               if (want[127:64] !== got[127:64])
                  report_mismatch("out_word_2", want[127:64], got[127:64]);
               if (want[63:0] !== got[63:0])
                  report_mismatch("out_word_3", want[63:0], got[63:0]);
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // The long receiver hold-off is counted here; the test sequence only asks
   // for one by bumping hold_request.
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = 600;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------ Test sequence
   // Writes one register and mirrors the write in the shadow settings once
   // the transfer has happened.
   task automatic write_csr(input logic [2:0] index, input logic [63:0] data);
      csr_index <= index;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_KEY_0:        key_bits[255:192] = data;
         CSR_KEY_1:        key_bits[191:128] = data;
         CSR_KEY_2:        key_bits[127:64] = data;
         CSR_KEY_3:        key_bits[63:0] = data;
         CSR_KEY_LENGTH:   key_code = data[1:0];
         CSR_BLOCK_LENGTH: blk_code = data[1:0];
         default: ;
      endcase
      if (index <= CSR_BLOCK_LENGTH) sched_valid = 1'b0;
   endtask

   task automatic program_settings(input logic [255:0] key, input logic [1:0] kc,
                                   input logic [1:0] bc);
      write_csr(CSR_KEY_0, key[255:192]);
      write_csr(CSR_KEY_1, key[191:128]);
      write_csr(CSR_KEY_2, key[127:64]);
      write_csr(CSR_KEY_3, key[63:0]);
      // Upper data bits of the length registers are noise.
      write_csr(CSR_KEY_LENGTH, {$urandom, 30'($urandom), kc});
      write_csr(CSR_BLOCK_LENGTH, {$urandom, 30'($urandom), bc});
      // Writes past the register map must not disturb anything.
      if ($urandom_range(1)) write_csr(CSR_SPARE_6, {$urandom, $urandom});
      if ($urandom_range(1)) write_csr(CSR_SPARE_7, {$urandom, $urandom});
   endtask

   // Waits until every block has been offered, transferred and answered.
   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_blocks.size() > 0)
         @(posedge clock);
      repeat ($urandom_range(3, 10)) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic cipher_item_type rand_item();
      cipher_item_type it;
      it.command = 1'($urandom_range(1));
      it.block = {rand_word(), rand_word(), rand_word(), rand_word()};
      return it;
   endfunction

   function automatic cipher_item_type make_item(input logic cmd, input logic [255:0] blk);
      cipher_item_type it;
      it.command = cmd;
      it.block = blk;
      return it;
   endfunction

   initial begin
      logic [255:0] key;
      logic [255:0] pattern [6];
      for (int i = 0; i < 256; i++) begin
         logic [7:0] b;
         b = gf_reciprocal(8'(i));
         fwd_sub[i] = b ^ rot_byte(b, 1) ^ rot_byte(b, 2) ^ rot_byte(b, 3) ^
                      rot_byte(b, 4) ^ 8'h63;
         rev_sub[i] = gf_reciprocal(rot_byte(8'(i), 1) ^ rot_byte(8'(i), 3) ^
                                    rot_byte(8'(i), 6) ^ 8'h05);
      end
      key_bits = '0;
      key_code = 2'd0;
      blk_code = 2'd0;
      sched_valid = 1'b0;
      pattern[0] = '0;
      pattern[1] = '1;
      pattern[2] = {8{32'h00112233}} ^ {64'h0, 64'h0011223344556677, 128'h0};
      pattern[3] = {64{4'h5}};
      pattern[4] = {64{4'ha}};
      pattern[5] = {128{2'b01}} ^ {32{8'h80}};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: smallest sizes with the textbook key, then the length
      // code three under all-ones key material, then a 32-byte key with 24-byte
      // blocks under a zero key. Fields at both extremes, both commands.
      program_settings({128'h000102030405060708090a0b0c0d0e0f, 128'h0}, 2'd0, 2'd0);
      pending_items.push_back(make_item(CMD_ENCRYPT,
                              {128'h00112233445566778899aabbccddeeff, 128'h0}));
      pending_items.push_back(make_item(CMD_DECRYPT,
                              {128'h69c4e0d86a7b0430d8cdb78070b4c55a, 128'h0}));
      for (int i = 0; i < 4; i++) pending_items.push_back(make_item(i[0], pattern[i]));
      drain();
      program_settings('1, 2'd3, 2'd3);
      for (int i = 0; i < 6; i++) pending_items.push_back(make_item(i[0], pattern[i]));
      for (int i = 0; i < 6; i++) pending_items.push_back(make_item(~i[0], pattern[i]));
      drain();
      program_settings('0, 2'd2, 2'd1);
      for (int i = 0; i < 6; i++) pending_items.push_back(make_item(i[0], pattern[i]));
      drain();

      // Random part: fourteen settings, walking through the idling phases.
      for (int ph = 0; ph < 14; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         key = {rand_word(), rand_word(), rand_word(), rand_word()};
         program_settings(key, 2'($urandom_range(3)), 2'($urandom_range(3)));
         // The receiver holds off for a long stretch while the sender keeps
         // offering, so the core fills and stalls its request channel.
         if (ph == 4 || ph == 11) hold_request++;
         for (int n = 0; n < 125; n++) pending_items.push_back(rand_item());
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_blocks.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (expected_blocks.size() != 0)
            $display("%0d result blocks never arrived", expected_blocks.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== rijndael_block_cipher.f =====
design/rbc_pkg.sv
design/rbc_ram.sv
design/rijndael_block_cipher.sv
design/rbc_checker.sv
tb/rijndael_block_cipher_tb.sv
